// ===== rtl/sha256_pkg.sv =====
`default_nettype none
package sha256_pkg;

	localparam int unsigned CountWidth = 61;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
	} in_word_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} ctl_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic       take_byte;
		logic       clr_count;
		logic       pad_write;
		logic       pad_mark;   // this pass places the 0x80 end marker
		logic       pad_len;    // this pass places the bit length
		logic [5:0] pad_pos;
		logic       load;
		logic       round;
		logic [5:0] round_idx;
		logic       add_hash;
		logic       init_hash;
		logic [2:0] emit_idx;
	} sha_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [5:0] fill;
	} sha_sts_t;

	function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] r;
		case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return k[t];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/sha256_dp.sv =====
`default_nettype none
module sha256_dp (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [7:0]            data_byte,
	input  wire sha256_pkg::sha_cmd_t  cmd,
	output sha256_pkg::sha_sts_t       sts,
	output logic [31:0]                digest_word
);

	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [sha256_pkg::CountWidth-1:0] cnt_q;
	logic [63:0] bits;
	logic [31:0] w15, w2, wn, wt, t1, t2;
	logic [7:0]  pad_byte;
	logic [5:0]  wr_pos;
	logic [7:0]  wr_byte;

	assign sts.fill = cnt_q[5:0];
	assign bits = {cnt_q, 3'b000};
	assign digest_word = h_q[cmd.emit_idx];

	// byte count, cleared at end of message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.clr_count) begin
			cnt_q <= '0;
		end else if (cmd.take_byte) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// padding byte: end marker, length byte or zero
	always_comb begin
		if (cmd.pad_mark && cmd.pad_pos == cnt_q[5:0]) begin
			pad_byte = 8'h80;
		end else if (cmd.pad_len && cmd.pad_pos >= 6'd56) begin
			pad_byte = bits[{~cmd.pad_pos[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	// bytes go straight into the schedule words, big-endian
	assign wr_pos  = cmd.take_byte ? cnt_q[5:0] : cmd.pad_pos;
	assign wr_byte = cmd.take_byte ? data_byte : pad_byte;

	// rolling message schedule
	assign w15 = w_q[1];
	assign w2  = w_q[14];
	assign wn  = w_q[0] + (sha256_pkg::ror(w15, 7) ^ sha256_pkg::ror(w15, 18) ^ (w15 >> 3))
		+ w_q[9] + (sha256_pkg::ror(w2, 17) ^ sha256_pkg::ror(w2, 19) ^ (w2 >> 10));
	assign wt  = (cmd.round_idx < 6'd16) ? w_q[0] : wn;

	// round function
	assign t1 = v_q[7] + (sha256_pkg::ror(v_q[4], 6) ^ sha256_pkg::ror(v_q[4], 11)
		^ sha256_pkg::ror(v_q[4], 25)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ sha256_pkg::round_k(cmd.round_idx) + wt;
	assign t2 = (sha256_pkg::ror(v_q[0], 2) ^ sha256_pkg::ror(v_q[0], 13)
		^ sha256_pkg::ror(v_q[0], 22)) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2])
		^ (v_q[1] & v_q[2]));

	always_ff @(posedge clk) begin
		if (cmd.take_byte || cmd.pad_write) begin
			w_q[wr_pos[5:2]][{~wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
		end else if (cmd.load) begin
			for (int j = 0; j < 8; j++) begin
				v_q[j] <= h_q[j];
			end
		end else if (cmd.round) begin
			for (int j = 0; j < 15; j++) begin
				w_q[j] <= w_q[j+1];
			end
			w_q[15] <= wt;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// hash words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 8; j++) begin
				h_q[j] <= sha256_pkg::init_h(3'(j));
			end
		end else if (cmd.init_hash) begin
			for (int j = 0; j < 8; j++) begin
				h_q[j] <= sha256_pkg::init_h(3'(j));
			end
		end else if (cmd.add_hash) begin
			for (int j = 0; j < 8; j++) begin
				h_q[j] <= h_q[j] + v_q[j];
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sha256_ctl.sv =====
`default_nettype none
module sha256_ctl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire sha256_pkg::in_word_t       in_data,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output sha256_pkg::out_word_t           out_data,
	input  wire logic [31:0]                digest_word,
	input  wire sha256_pkg::sha_sts_t       sts,
	output sha256_pkg::sha_cmd_t            cmd
);

	sha256_pkg::ctl_state_t state_q, state_d;
	logic [5:0] idx_q, idx_d;
	logic       fin_q, fin_d;   // finalizing the message
	logic       pad_q, pad_d;   // padding of this message has started
	logic       two_q, two_d;   // a second padding block follows
	logic [2:0] emit_q, emit_d;
	logic       acc;

	assign acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256_pkg::ST_IDLE;
			idx_q   <= '0;
			fin_q   <= 1'b0;
			pad_q   <= 1'b0;
			two_q   <= 1'b0;
			emit_q  <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			fin_q   <= fin_d;
			pad_q   <= pad_d;
			two_q   <= two_d;
			emit_q  <= emit_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		fin_d   = fin_q;
		pad_d   = pad_q;
		two_d   = two_q;
		emit_d  = emit_q;
		cmd     = '0;
		cmd.pad_pos   = idx_q;
		cmd.round_idx = idx_q;
		cmd.emit_idx  = emit_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			sha256_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (acc) begin
					cmd.take_byte = in_data.has_byte;
					fin_d = in_data.last;
					if (in_data.has_byte && sts.fill == 6'd63) begin
						state_d = sha256_pkg::ST_LOAD;
					end else if (in_data.last) begin
						state_d = sha256_pkg::ST_PAD;
						idx_d = in_data.has_byte ? sts.fill + 6'd1 : sts.fill;
						pad_d = 1'b1;
						two_d = 1'b0;
					end
				end
			end
			sha256_pkg::ST_PAD: begin
				// first pass marks 0x80 and zeroes; length goes in when it fits
				cmd.pad_write = 1'b1;
				cmd.pad_mark  = !two_q;
				cmd.pad_len   = two_q || (sts.fill < 6'd56);
				if (idx_q == 6'd63) begin
					state_d = sha256_pkg::ST_LOAD;
				end
				idx_d = idx_q + 6'd1;
			end
			sha256_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
				idx_d = '0;
				state_d = sha256_pkg::ST_ROUND;
			end
			sha256_pkg::ST_ROUND: begin
				cmd.round = 1'b1;
				idx_d = idx_q + 6'd1;
				if (idx_q == 6'd63) begin
					state_d = sha256_pkg::ST_ADD;
				end
			end
			sha256_pkg::ST_ADD: begin
				cmd.add_hash = 1'b1;
				if (!fin_q) begin
					state_d = sha256_pkg::ST_IDLE;
				end else if (!pad_q) begin
					// last byte closed a block: a full padding block follows
					pad_d = 1'b1;
					two_d = 1'b0;
					idx_d = sts.fill;
					state_d = sha256_pkg::ST_PAD;
				end else if (!two_q && sts.fill >= 6'd56) begin
					// length did not fit: zero block with length follows
					two_d = 1'b1;
					idx_d = '0;
					state_d = sha256_pkg::ST_PAD;
				end else begin
					emit_d = '0;
					state_d = sha256_pkg::ST_EMIT;
				end
			end
			sha256_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					emit_d = emit_q + 3'd1;
					if (emit_q == 3'd7) begin
						cmd.init_hash = 1'b1;
						cmd.clr_count = 1'b1;
						fin_d = 1'b0;
						pad_d = 1'b0;
						two_d = 1'b0;
						state_d = sha256_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = sha256_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_data.digest_word = digest_word;
	assign out_data.word_index  = emit_q;
	assign out_data.last_word   = (emit_q == 3'd7);

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != sha256_pkg::ST_IDLE) |-> !in_ready)
		else $error("input taken while busy");
	a_emit_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && emit_q != 3'd7) |=> (emit_q == $past(emit_q) + 3'd1))
		else $error("digest word order broken");
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha256_pkg::ST_ROUND && idx_q == 6'd63) |=>
		(state_q == sha256_pkg::ST_ADD))
		else $error("compression did not end after 64 rounds");
`endif

endmodule
`default_nettype wire

// ===== rtl/sha256_stream_hash.sv =====
`default_nettype none
// Streaming SHA-256 hash engine.
// Input channel (in_valid/in_ready/in_data): one word per message byte;
// has_byte=0 with last=1 closes the message without adding a byte, has_byte=0 last=0 is a no-op.
// Output channel (out_valid/out_ready/out_data): eight digest words after a
// last word, most significant first, last_word set on the eighth.
// A byte word is taken while idle; the 64th byte of a block starts a
// compression (load, 64 rounds of one shared round unit, add).
// After a last word the rest of the open block (n = bytes in it) gets padding
// writes, one byte per cycle, then a compression; when n is 56 or more a zero
// block with the length is padded and compressed as well; when the last byte
// closes a block, its compression comes first and a full padding block
// follows.
// Digest words then leave one per cycle while out_ready is high.
// in_ready is low while padding, compressing or emitting.
// Reset loads the initial hash values and clears the byte count.
// A stalled receiver holds the current digest word; nothing is lost.
module sha256_stream_hash (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire sha256_pkg::in_word_t  in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output sha256_pkg::out_word_t      out_data
);

	sha256_pkg::sha_cmd_t cmd;
	sha256_pkg::sha_sts_t sts;
	logic [31:0]          digest_word;

	sha256_ctl u_ctl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.digest_word(digest_word), .sts(sts), .cmd(cmd)
	);

	sha256_dp u_dp (
		.clk(clk), .arst_n(arst_n), .data_byte(in_data.data_byte),
		.cmd(cmd), .sts(sts), .digest_word(digest_word)
	);

endmodule
`default_nettype wire
